// ===== hdl/sicp_pkg.sv =====
package sicp_pkg;

    localparam int NUM_REGS_DEFAULT = 22;
    localparam int INDEX_W          = 5;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] OFF_KEY   = 2'd0;
    localparam logic [1:0] OFF_INDEX = 2'd1;
    localparam logic [1:0] OFF_DATA  = 2'd2;

    localparam logic [4:0] REG_FDC    = 5'h00;
    localparam logic [4:0] REG_PORTS  = 5'h01;
    localparam logic [4:0] REG_SERSEL = 5'h03;
    localparam logic [4:0] REG_DIS    = 5'h04;
    localparam logic [4:0] REG_FDCDIS = 5'h06;
    localparam logic [4:0] REG_DTYPE  = 5'h07;
    localparam logic [4:0] REG_STRAP  = 5'h09;
    localparam logic [4:0] REG_KEYSEL = 5'h0C;

    localparam logic [7:0] KEY_BASE    = 8'h88;
    localparam logic [7:0] INDEX_MAX   = 8'h15;
    localparam logic [7:0] REG6_MASK   = 8'hF3;
    localparam logic [7:0] READ_IDLE   = 8'hFF;

    localparam logic [9:0] COM_3F8 = 10'h3F8;
    localparam logic [9:0] COM_2F8 = 10'h2F8;
    localparam logic [9:0] COM_3E8 = 10'h3E8;
    localparam logic [9:0] COM_2E8 = 10'h2E8;
    localparam logic [9:0] LPT_3BC = 10'h3BC;
    localparam logic [9:0] LPT_278 = 10'h278;
    localparam logic [9:0] LPT_378 = 10'h378;
    localparam logic [9:0] FDC_3F0 = 10'h3F0;
    localparam logic [9:0] FDC_370 = 10'h370;
    localparam logic [8:0] IDE_1F0 = 9'h1F0;
    localparam logic [8:0] IDE_170 = 9'h170;

    localparam int CFG_HAS_DISK = 0;
    localparam int CFG_REG9     = 1;

    // register values that feed the resource decode, post-update
    typedef struct packed {
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r3;
        logic [7:0] r4;
        logic [7:0] r6;
    } sicp_view_t;

    typedef struct packed {
        logic [9:0] com_a_base;
        logic [2:0] com_a_irq;
        logic [9:0] com_b_base;
        logic [2:0] com_b_irq;
        logic [9:0] printer_base;
        logic [9:0] floppy_base;
        logic [8:0] disk_base;
        logic       drive_swap;
    } sicp_decode_t;

    typedef struct packed {
        logic       we;
        logic [7:0] reg9;
    } sicp_cfg_t;

    function automatic logic [7:0] reset_value(input int idx);
        logic [7:0] v;
        v = 8'h00;
        unique case (idx)
            0:       v = 8'h50;
            1:       v = 8'h2C;
            3:       v = 8'h30;
            7:       v = 8'hF5;
            10:      v = 8'h1F;
            12:      v = 8'h2C;
            13:      v = 8'hA3;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/sicp_req_if.sv =====
interface sicp_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] port_offset;
    logic [7:0] write_data;

    modport source (output valid, output cmd, output port_offset, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input port_offset, input write_data,
                    output ready);
endinterface

// ===== hdl/sicp_rsp_if.sv =====
interface sicp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [9:0] com_a_base;
    logic [2:0] com_a_irq;
    logic [9:0] com_b_base;
    logic [2:0] com_b_irq;
    logic [9:0] printer_base;
    logic [9:0] floppy_base;
    logic [8:0] disk_base;
    logic       drive_swap;
    logic       unlocked;
    logic       writes_frozen;

    modport source (output valid, output read_data, output com_a_base, output com_a_irq,
                    output com_b_base, output com_b_irq, output printer_base,
                    output floppy_base, output disk_base, output drive_swap,
                    output unlocked, output writes_frozen, input ready);
    modport sink   (input valid, input read_data, input com_a_base, input com_a_irq,
                    input com_b_base, input com_b_irq, input printer_base,
                    input floppy_base, input disk_base, input drive_swap,
                    input unlocked, input writes_frozen, output ready);
endinterface

// ===== hdl/sicp_regfile.sv =====
module sicp_regfile #(
    parameter int NUM_REGS = sicp_pkg::NUM_REGS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 cmd,
    input  logic [1:0]           port_offset,
    input  logic [7:0]           write_data,
    input  sicp_pkg::sicp_cfg_t  cfg,
    output logic [7:0]           read_data,
    output sicp_pkg::sicp_view_t view_next,
    output logic                 unlock_next,
    output logic                 freeze_next
);

    localparam int IDX_W = $clog2(NUM_REGS);

    logic [7:0]                      regs_reg [NUM_REGS];
    logic [7:0]                      regs_next [NUM_REGS];
    logic [sicp_pkg::INDEX_W-1:0]    index_reg;
    logic [sicp_pkg::INDEX_W-1:0]    index_next;
    logic                            unlock_reg;
    logic                            freeze_reg;

    logic                            index_ok;
    logic [7:0]                      cur_val;
    logic [7:0]                      wr_val;
    logic [7:0]                      key;

    assign index_ok = (6'(index_reg) < 6'(NUM_REGS));
    assign cur_val  = index_ok ? regs_reg[index_reg[IDX_W-1:0]] : 8'h00;
    assign key      = sicp_pkg::KEY_BASE
                      | {7'b0, regs_reg[sicp_pkg::REG_KEYSEL[IDX_W-1:0]][5]};
    assign wr_val   = (index_reg == sicp_pkg::REG_FDCDIS)
                      ? (write_data & sicp_pkg::REG6_MASK) : write_data;

    // read path sees the state before the access
    always_comb
    begin
        read_data = sicp_pkg::READ_IDLE;
        if (cmd == sicp_pkg::CMD_READ && unlock_reg)
        begin
            if (port_offset == sicp_pkg::OFF_INDEX)
                read_data = {3'b0, index_reg};
            else if (port_offset == sicp_pkg::OFF_DATA)
            begin
                if (index_reg == sicp_pkg::REG_DTYPE)
                    read_data = {4'b0, cur_val[3:0]};
                else if (!freeze_reg)
                    read_data = cur_val;
            end
        end
    end

    always_comb
    begin
        regs_next   = regs_reg;
        index_next  = index_reg;
        unlock_next = unlock_reg;
        freeze_next = freeze_reg;
        if (accept && cmd == sicp_pkg::CMD_WRITE)
        begin
            if (port_offset == sicp_pkg::OFF_KEY)
                unlock_next = (write_data == key);
            else if (port_offset == sicp_pkg::OFF_INDEX)
            begin
                if (write_data <= sicp_pkg::INDEX_MAX)
                    index_next = write_data[sicp_pkg::INDEX_W-1:0];
            end
            else if (port_offset == sicp_pkg::OFF_DATA && unlock_reg && !freeze_reg
                     && index_ok)
            begin
                regs_next[index_reg[IDX_W-1:0]] = wr_val;
                if (index_reg == sicp_pkg::REG_STRAP && (cur_val[6] ^ wr_val[6]))
                    freeze_next = wr_val[6];
            end
        end
        if (cfg.we)
            regs_next[sicp_pkg::REG_STRAP[IDX_W-1:0]] = cfg.reg9;
    end

    assign view_next.r0 = regs_next[sicp_pkg::REG_FDC[IDX_W-1:0]];
    assign view_next.r1 = regs_next[sicp_pkg::REG_PORTS[IDX_W-1:0]];
    assign view_next.r3 = regs_next[sicp_pkg::REG_SERSEL[IDX_W-1:0]];
    assign view_next.r4 = regs_next[sicp_pkg::REG_DIS[IDX_W-1:0]];
    assign view_next.r6 = regs_next[sicp_pkg::REG_FDCDIS[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= sicp_pkg::reset_value(i);
            index_reg  <= '0;
            unlock_reg <= 1'b0;
            freeze_reg <= 1'b0;
        end
        else
        begin
            regs_reg   <= regs_next;
            index_reg  <= index_next;
            unlock_reg <= unlock_next;
            freeze_reg <= freeze_next;
        end
    end

endmodule

// ===== hdl/sicp_decode.sv =====
module sicp_decode (
    input  sicp_pkg::sicp_view_t   view,
    input  logic                   has_disk_port,
    output sicp_pkg::sicp_decode_t dec
);

    // serial port: select bit, two-bit code, disable
    function automatic logic [12:0] serial(input logic u, input logic s0, input logic s1,
                                           input logic s2, input logic dis);
        logic [9:0] a;
        logic [2:0] q;
        a = 10'd0;
        q = 3'd0;
        if (s2)
        begin
            a = u ? sicp_pkg::COM_3F8 : sicp_pkg::COM_2F8;
            q = u ? 3'd4 : 3'd3;
        end
        else
        begin
            unique case ({s1, s0})
                2'b00:
                begin
                    a = u ? sicp_pkg::COM_3E8 : sicp_pkg::COM_2E8;
                    q = u ? 3'd4 : 3'd3;
                end
                2'b01:
                begin
                    a = u ? sicp_pkg::COM_2E8 : sicp_pkg::COM_3E8;
                    q = u ? 3'd3 : 3'd4;
                end
                2'b10:
                begin
                    a = u ? sicp_pkg::COM_2F8 : sicp_pkg::COM_3F8;
                    q = u ? 3'd3 : 3'd4;
                end
                default:
                begin
                    a = 10'd0;
                    q = 3'd0;
                end
            endcase
        end
        if (dis)
        begin
            a = 10'd0;
            q = 3'd0;
        end
        return {a, q};
    endfunction

    always_comb
    begin
        {dec.com_a_base, dec.com_a_irq} =
            serial(1'b0, view.r1[0], view.r1[2], view.r3[3], view.r4[5]);
        {dec.com_b_base, dec.com_b_irq} =
            serial(1'b1, view.r1[1], view.r1[3], view.r3[2], view.r4[4]);

        unique case (view.r1[5:4])
            2'd0:    dec.printer_base = sicp_pkg::LPT_3BC;
            2'd1:    dec.printer_base = sicp_pkg::LPT_278;
            2'd2:    dec.printer_base = sicp_pkg::LPT_378;
            default: dec.printer_base = 10'd0;
        endcase
        if (view.r4[7])
            dec.printer_base = 10'd0;

        if (!view.r0[5] && !view.r6[3])
            dec.floppy_base = view.r0[4] ? sicp_pkg::FDC_3F0 : sicp_pkg::FDC_370;
        else
            dec.floppy_base = 10'd0;

        if (has_disk_port && view.r0[7])
            dec.disk_base = view.r0[6] ? sicp_pkg::IDE_1F0 : sicp_pkg::IDE_170;
        else
            dec.disk_base = 9'd0;

        dec.drive_swap = view.r1[7];
    end

endmodule

// ===== hdl/superio_config_port_core.sv =====
// Super I/O configuration port core.
//
// req carries one bus access per request (cmd, port_offset, write_data):
// offset 0 takes the unlock key, 1 the register index, 2 the register data.
// rsp returns one result per request: the read byte plus the serial,
// printer, floppy and disk resources decoded from the register file as it
// stands after the access, and the unlock / freeze status.
//
// Latency: the result is registered and valid the cycle after the request
// is taken. Throughput: one request per cycle; the register file update and
// the decode are a single combinational pass into the result register.
// req.ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds the result and blocks only the next request.
//
// Reset (rst_n, async low) loads the register file strap defaults, clears
// index, unlock and freeze, and empties the result register.
// cfg_write_en/cfg_index/cfg_data write has_disk_port (0) or the register 9
// strap (1); the strap write also loads register 9. Write only when idle.
module superio_config_port_core #(
    parameter int NUM_REGS = sicp_pkg::NUM_REGS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    sicp_req_if.sink   req,
    sicp_rsp_if.source rsp,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic                   accept;
    logic                   has_disk_reg;
    sicp_pkg::sicp_cfg_t    cfg;
    logic [7:0]             rdata;
    sicp_pkg::sicp_view_t   view_next;
    logic                   unlock_next;
    logic                   freeze_next;
    sicp_pkg::sicp_decode_t dec;

    // result register
    logic                   rsp_valid_reg;
    logic [7:0]             read_data_reg;
    sicp_pkg::sicp_decode_t dec_reg;
    logic                   unlocked_reg;
    logic                   frozen_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cfg.we   = cfg_write_en && (cfg_index == 1'(sicp_pkg::CFG_REG9));
    assign cfg.reg9 = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            has_disk_reg <= 1'b0;
        else if (cfg_write_en && cfg_index == 1'(sicp_pkg::CFG_HAS_DISK))
            has_disk_reg <= cfg_data[0];
    end

    sicp_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (req.cmd),
        .port_offset (req.port_offset),
        .write_data  (req.write_data),
        .cfg         (cfg),
        .read_data   (rdata),
        .view_next   (view_next),
        .unlock_next (unlock_next),
        .freeze_next (freeze_next)
    );

    // decode of the post-access register view
    sicp_decode u_decode (
        .view          (view_next),
        .has_disk_port (has_disk_reg),
        .dec           (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= rdata;
            dec_reg       <= dec;
            unlocked_reg  <= unlock_next;
            frozen_reg    <= freeze_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = read_data_reg;
    assign rsp.com_a_base    = dec_reg.com_a_base;
    assign rsp.com_a_irq     = dec_reg.com_a_irq;
    assign rsp.com_b_base    = dec_reg.com_b_base;
    assign rsp.com_b_irq     = dec_reg.com_b_irq;
    assign rsp.printer_base  = dec_reg.printer_base;
    assign rsp.floppy_base   = dec_reg.floppy_base;
    assign rsp.disk_base     = dec_reg.disk_base;
    assign rsp.drive_swap    = dec_reg.drive_swap;
    assign rsp.unlocked      = unlocked_reg;
    assign rsp.writes_frozen = frozen_reg;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import sicp_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int N_PHASES       = 8;
    localparam int RAND_PER_PHASE = 190;   // random requests per phase, fewer in the last
    localparam int PRESSURE_PHASE = 2;     // receiver holds off once, in this phase
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 3;     // result shows the cycle after its request is taken
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;
    localparam int FREEZE_BIT     = 6;     // register 9 bit that freezes the port
    localparam int N_DIR          = 26;

    // offset 3 is unused by the port but reachable through the 2-bit field
    localparam logic [1:0] OFF_SPARE = 2'd3;

    // idle profiles: {sender idle %, receiver stall %}
    localparam int MODE_FLAT   = 0;
    localparam int MODE_SRC    = 1;
    localparam int MODE_SNK    = 2;
    localparam int MODE_BOTH   = 3;
    localparam int STRAP_RANDOM = -1;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_en;
    logic       cfg_index;
    logic [7:0] cfg_data;

    sicp_req_if req();
    sicp_rsp_if rsp();

    superio_config_port_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // One result as seen on rsp, and what the scoreboard keeps per request
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] read_data;
        logic [9:0] com_a_base;
        logic [2:0] com_a_irq;
        logic [9:0] com_b_base;
        logic [2:0] com_b_irq;
        logic [9:0] printer_base;
        logic [9:0] floppy_base;
        logic [8:0] disk_base;
        logic       drive_swap;
        logic       unlocked;
        logic       writes_frozen;
    } port_view_t;

    typedef struct {
        port_view_t view;
        bit         pinned;      // directed row with a hand-typed read byte
        logic [7:0] pin_rd;
    } view_exp_t;

    // directed table row: access plus, where obvious, the read byte
    typedef struct packed {
        logic       cmd;
        logic [1:0] off;
        logic [7:0] data;
        logic       pinned;
        logic [7:0] pin_rd;
    } stim_row_t;

    // Directed walk from reset: key register 0x0C starts with bit 5 set, so the
    // live key is 0x89 and the bare base key must not unlock.
    stim_row_t dir_rows [N_DIR] = '{
        '{CMD_READ,  OFF_KEY,   8'h00, 1'b1, READ_IDLE},   // locked: key port read
        '{CMD_READ,  OFF_DATA,  8'h00, 1'b1, READ_IDLE},   // locked: data read
        '{CMD_WRITE, OFF_DATA,  8'h00, 1'b1, READ_IDLE},   // locked: write dropped
        '{CMD_WRITE, OFF_KEY,   KEY_BASE, 1'b1, READ_IDLE},// base key is wrong here
        '{CMD_WRITE, OFF_KEY,   KEY_BASE | 8'h01, 1'b1, READ_IDLE}, // unlock
        '{CMD_READ,  OFF_INDEX, 8'h00, 1'b1, 8'h00},
        '{CMD_READ,  OFF_DATA,  8'h00, 1'b1, 8'h50},       // reg 0 survived the drop
        '{CMD_WRITE, OFF_INDEX, INDEX_MAX, 1'b0, 8'h00},   // top legal index
        '{CMD_READ,  OFF_INDEX, 8'h00, 1'b1, INDEX_MAX},
        '{CMD_WRITE, OFF_INDEX, 8'h16, 1'b0, 8'h00},       // just past the top
        '{CMD_READ,  OFF_INDEX, 8'h00, 1'b1, INDEX_MAX},
        '{CMD_WRITE, OFF_INDEX, 8'hFF, 1'b0, 8'h00},       // far out, also ignored
        '{CMD_WRITE, OFF_INDEX, 8'h07, 1'b0, 8'h00},
        '{CMD_READ,  OFF_DATA,  8'h00, 1'b1, 8'h05},       // drive types only
        '{CMD_WRITE, OFF_INDEX, 8'h06, 1'b0, 8'h00},
        '{CMD_WRITE, OFF_DATA,  8'hFF, 1'b0, 8'h00},
        '{CMD_READ,  OFF_DATA,  8'h00, 1'b1, REG6_MASK},   // masked store
        '{CMD_WRITE, OFF_SPARE, 8'hAA, 1'b1, READ_IDLE},
        '{CMD_READ,  OFF_SPARE, 8'h00, 1'b1, READ_IDLE},
        '{CMD_WRITE, OFF_INDEX, 8'h01, 1'b0, 8'h00},
        '{CMD_WRITE, OFF_DATA,  8'hFF, 1'b0, 8'h00},       // select 3, printer off, swap
        '{CMD_WRITE, OFF_INDEX, 8'h04, 1'b0, 8'h00},
        '{CMD_WRITE, OFF_DATA,  8'hFF, 1'b0, 8'h00},       // every disable bit
        '{CMD_WRITE, OFF_INDEX, 8'h0C, 1'b0, 8'h00},
        '{CMD_WRITE, OFF_DATA,  8'h00, 1'b0, 8'h00},       // key drops to base
        '{CMD_WRITE, OFF_KEY,   KEY_BASE | 8'h01, 1'b1, READ_IDLE} // old key locks
    };

    int  phase_mode  [N_PHASES] = '{MODE_FLAT, MODE_SRC, MODE_SNK, MODE_BOTH,
                                    MODE_FLAT, MODE_SRC, MODE_SNK, MODE_BOTH};
    bit  phase_disk  [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    int  phase_strap [N_PHASES] = '{8'h00, 8'hFF, STRAP_RANDOM, 8'h40,
                                    STRAP_RANDOM, STRAP_RANDOM, 8'hBF, STRAP_RANDOM};

    // ------------------------------------------------------------------
    // Predictor state: shadow of the register file and port flags
    // ------------------------------------------------------------------
    logic [7:0] cfg_regs [NUM_REGS_DEFAULT];
    logic [4:0] sel_index;
    bit         port_open;
    bit         port_frozen;
    bit         disk_present;
    logic [7:0] strap9;

    view_exp_t  view_q [$];

    int  src_idle_pct;
    int  snk_stall_pct;
    bit  pressure_on;
    bit  freeze_seen;
    int  accepted;
    int  checked;
    int  mismatches;
    int  cycles;
    int  drain_wait;
    int  phase;
    int  strap_val;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic load_defaults();
        for (int i = 0; i < NUM_REGS_DEFAULT; i++)
            cfg_regs[i] = 8'h00;
        cfg_regs[REG_FDC]    = 8'h50;
        cfg_regs[REG_PORTS]  = 8'h2C;
        cfg_regs[REG_SERSEL] = 8'h30;
        cfg_regs[REG_DTYPE]  = 8'hF5;
        cfg_regs[5'h0A]      = 8'h1F;
        cfg_regs[REG_KEYSEL] = 8'h2C;
        cfg_regs[5'h0D]      = 8'hA3;
        strap9               = 8'h00;
        cfg_regs[REG_STRAP]  = strap9;
        disk_present         = 1'b0;
        sel_index            = '0;
        port_open            = 1'b0;
        port_frozen          = 1'b0;
    endtask

    function automatic logic [7:0] live_key();
        return KEY_BASE | {7'd0, cfg_regs[REG_KEYSEL][5]};
    endfunction

    // u = 0 first serial port, u = 1 second
    function automatic void com_decode(input bit u, output logic [9:0] base,
                                       output logic [2:0] irq);
        logic       s0;
        logic       s1;
        logic       s2;
        logic [1:0] sel;
        s0   = cfg_regs[REG_PORTS][u];
        s1   = cfg_regs[REG_PORTS][2 + u];
        s2   = cfg_regs[REG_SERSEL][3 - u];
        sel  = {s1, s0};
        base = '0;
        irq  = '0;
        if (s2)
        begin
            base = u ? COM_3F8 : COM_2F8;
            irq  = u ? 3'd4 : 3'd3;
        end
        else
        begin
            case (sel)
                2'd0:
                begin
                    base = u ? COM_3E8 : COM_2E8;
                    irq  = u ? 3'd4 : 3'd3;
                end
                2'd1:
                begin
                    base = u ? COM_2E8 : COM_3E8;
                    irq  = u ? 3'd3 : 3'd4;
                end
                2'd2:
                begin
                    base = u ? COM_2F8 : COM_3F8;
                    irq  = u ? 3'd3 : 3'd4;
                end
                default:
                begin
                    base = '0;
                    irq  = '0;
                end
            endcase
        end
        if (cfg_regs[REG_DIS][5 - u])
        begin
            base = '0;
            irq  = '0;
        end
    endfunction

    // Apply one access to the shadow and return the result it should produce.
    function automatic port_view_t predict_access(input logic c, input logic [1:0] o,
                                                  input logic [7:0] wd);
        port_view_t v;
        logic [7:0] old_val;
        logic [7:0] val;
        logic [7:0] r0;
        val         = wd;
        v           = '0;
        v.read_data = READ_IDLE;
        if (c == CMD_WRITE)
        begin
            if (o == OFF_KEY)
                port_open = (val == live_key());
            else if (o == OFF_INDEX)
            begin
                if (val <= INDEX_MAX)
                    sel_index = val[4:0];
            end
            else if (o == OFF_DATA && port_open && !port_frozen)
            begin
                old_val = cfg_regs[sel_index];
                if (sel_index == REG_FDCDIS)
                    val = val & REG6_MASK;
                cfg_regs[sel_index] = val;
                // freeze only follows a change of the freeze bit
                if (sel_index == REG_STRAP && old_val[FREEZE_BIT] != val[FREEZE_BIT])
                    port_frozen = val[FREEZE_BIT];
            end
        end
        else if (port_open)
        begin
            if (o == OFF_INDEX)
                v.read_data = {3'd0, sel_index};
            else if (o == OFF_DATA)
            begin
                // drive-type nibble stays readable through a freeze
                if (sel_index == REG_DTYPE)
                    v.read_data = cfg_regs[REG_DTYPE] & 8'h0F;
                else if (!port_frozen)
                    v.read_data = cfg_regs[sel_index];
            end
        end

        com_decode(1'b0, v.com_a_base, v.com_a_irq);
        com_decode(1'b1, v.com_b_base, v.com_b_irq);

        case (cfg_regs[REG_PORTS][5:4])
            2'd0:    v.printer_base = LPT_3BC;
            2'd1:    v.printer_base = LPT_278;
            2'd2:    v.printer_base = LPT_378;
            default: v.printer_base = '0;
        endcase
        if (cfg_regs[REG_DIS][7])
            v.printer_base = '0;

        r0 = cfg_regs[REG_FDC];
        if (!r0[5] && !cfg_regs[REG_FDCDIS][3])
            v.floppy_base = r0[4] ? FDC_3F0 : FDC_370;
        else
            v.floppy_base = '0;

        if (disk_present && r0[7])
            v.disk_base = r0[6] ? IDE_1F0 : IDE_170;
        else
            v.disk_base = '0;

        v.drive_swap    = cfg_regs[REG_PORTS][7];
        v.unlocked      = port_open;
        v.writes_frozen = port_frozen;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycles, view_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per phase, plus one long hold-off that lets
    // the result register fill and back-pressure the request side.
    // ------------------------------------------------------------------
    initial
    begin : rsp_side
        bit held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_on && !held)
            begin
                held = 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    rsp.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: in-order, field by field
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected 0x%0h got 0x%0h",
                     checked, what, want, got);
    endtask

    task automatic cmp_field(input string what, input int unsigned want,
                             input int unsigned got);
        if (want !== got)
            note_mismatch(what, want, got);
    endtask

    always @(posedge clk)
    begin : rsp_check
        view_exp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (view_q.size() == 0)
                note_mismatch("unexpected result", 0, rsp.read_data);
            else
            begin
                e = view_q.pop_front();
                cmp_field("read_data",     e.view.read_data,     rsp.read_data);
                cmp_field("com_a_base",    e.view.com_a_base,    rsp.com_a_base);
                cmp_field("com_a_irq",     e.view.com_a_irq,     rsp.com_a_irq);
                cmp_field("com_b_base",    e.view.com_b_base,    rsp.com_b_base);
                cmp_field("com_b_irq",     e.view.com_b_irq,     rsp.com_b_irq);
                cmp_field("printer_base",  e.view.printer_base,  rsp.printer_base);
                cmp_field("floppy_base",   e.view.floppy_base,   rsp.floppy_base);
                cmp_field("disk_base",     e.view.disk_base,     rsp.disk_base);
                cmp_field("drive_swap",    e.view.drive_swap,    rsp.drive_swap);
                cmp_field("unlocked",      e.view.unlocked,      rsp.unlocked);
                cmp_field("writes_frozen", e.view.writes_frozen, rsp.writes_frozen);
                if (e.pinned)
                    cmp_field("read_data (table)", e.pin_rd, rsp.read_data);
                checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Entered at a rising edge; returns at the edge the request is taken.
    // valid stays high until then, so it gets at most one update per edge.
    task automatic offer(input logic c, input logic [1:0] o, input logic [7:0] wd,
                         input bit pinned, input logic [7:0] pin_rd);
        view_exp_t e;
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= c;
        req.port_offset <= o;
        req.write_data  <= wd;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        e.view   = predict_access(c, o, wd);
        e.pinned = pinned;
        e.pin_rd = pin_rd;
        view_q.push_back(e);
        accepted++;
        if (port_frozen)
            freeze_seen = 1'b1;
    endtask

    // Mostly well-formed traffic: unlock with the live key, pick a legal
    // index, then read or write data. Some wrong keys, bad indexes and
    // offset-3 accesses mixed in. Unless a freeze is allowed, a data write
    // to register 9 never raises the freeze bit from 0.
    task automatic rand_access(input bit freeze_ok);
        int         pick;
        logic       c;
        logic [1:0] o;
        logic [7:0] wd;
        pick = $urandom_range(0, 99);
        wd   = 8'($urandom_range(0, 255));
        c    = CMD_WRITE;
        o    = OFF_DATA;
        if (pick < 14)
        begin
            o = OFF_KEY;
            if ($urandom_range(0, 3) != 0)
                wd = live_key();
        end
        else if (pick < 36)
        begin
            o = OFF_INDEX;
            if ($urandom_range(0, 6) != 0)
                wd = 8'($urandom_range(0, NUM_REGS_DEFAULT - 1));
        end
        else if (pick < 62)
            o = OFF_DATA;
        else if (pick < 86)
        begin
            c = CMD_READ;
            o = OFF_DATA;
        end
        else if (pick < 94)
        begin
            c = CMD_READ;
            o = $urandom_range(0, 1) ? OFF_INDEX : OFF_KEY;
        end
        else
        begin
            c = 1'($urandom_range(0, 1));
            o = OFF_SPARE;
        end
        if (!freeze_ok && c == CMD_WRITE && o == OFF_DATA && sel_index == REG_STRAP &&
            !cfg_regs[REG_STRAP][FREEZE_BIT])
            wd[FREEZE_BIT] = 1'b0;
        offer(c, o, wd, 1'b0, 8'h00);
    endtask

    // Wait for every owed result, then let the port settle. Anything still
    // owed past the drain limit counts as a failure.
    task automatic wait_quiet();
        drain_wait = 0;
        while (view_q.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (view_q.size() != 0)
        begin
            note_mismatch("results never arrived", 0, view_q.size());
            view_q.delete();
        end
    endtask

    // Both configuration registers, one per edge; block must be idle.
    task automatic apply_setting(input bit disk, input logic [7:0] strap);
        cfg_write_en <= 1'b1;
        cfg_index    <= 1'(CFG_HAS_DISK);
        cfg_data     <= {7'($urandom_range(0, 127)), disk};
        @(posedge clk);
        cfg_index    <= 1'(CFG_REG9);
        cfg_data     <= strap;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        disk_present        = disk;
        strap9              = strap;
        cfg_regs[REG_STRAP] = strap9;
    endtask

    task automatic set_mode(input int mode);
        case (mode)
            MODE_SRC:
            begin
                src_idle_pct  = 69;
                snk_stall_pct = 0;
            end
            MODE_SNK:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 69;
            end
            MODE_BOTH:
            begin
                src_idle_pct  = 33;
                snk_stall_pct = 33;
            end
            default:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        cfg_write_en     <= 1'b0;
        cfg_index        <= 1'b0;
        cfg_data         <= 8'h00;
        req.valid        <= 1'b0;
        req.cmd          <= CMD_READ;
        req.port_offset  <= OFF_KEY;
        req.write_data   <= 8'h00;
        accepted         = 0;
        checked          = 0;
        mismatches       = 0;
        pressure_on      = 1'b0;
        freeze_seen      = 1'b0;
        set_mode(MODE_FLAT);
        load_defaults();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset configuration, no idling
        for (int i = 0; i < N_DIR; i++)
            offer(dir_rows[i].cmd, dir_rows[i].off, dir_rows[i].data,
                  dir_rows[i].pinned, dir_rows[i].pin_rd);
        req.valid <= 1'b0;

        for (phase = 0; phase < N_PHASES; phase++)
        begin
            wait_quiet();
            strap_val = (phase_strap[phase] == STRAP_RANDOM) ? $urandom_range(0, 255)
                                                             : phase_strap[phase];
            apply_setting(phase_disk[phase], 8'(strap_val));
            set_mode(phase_mode[phase]);
            if (phase == PRESSURE_PHASE)
                pressure_on = 1'b1;

            if (phase == N_PHASES - 1)
            begin
                // last phase: freeze the port halfway, then keep going frozen
                repeat (RAND_PER_PHASE / 2) rand_access(1'b0);
                offer(CMD_WRITE, OFF_KEY, live_key(), 1'b0, 8'h00);
                offer(CMD_WRITE, OFF_INDEX, {3'd0, REG_STRAP}, 1'b0, 8'h00);
                if (cfg_regs[REG_STRAP][FREEZE_BIT])
                    offer(CMD_WRITE, OFF_DATA,
                          8'($urandom_range(0, 255)) & ~(8'h01 << FREEZE_BIT), 1'b0, 8'h00);
                offer(CMD_WRITE, OFF_DATA,
                      8'($urandom_range(0, 255)) | (8'h01 << FREEZE_BIT), 1'b0, 8'h00);
                offer(CMD_WRITE, OFF_INDEX, {3'd0, REG_DTYPE}, 1'b0, 8'h00);
                offer(CMD_READ, OFF_DATA, 8'h00, 1'b0, 8'h00);
                repeat (RAND_PER_PHASE - RAND_PER_PHASE / 2 - 6) rand_access(1'b1);
            end
            else
                repeat (RAND_PER_PHASE) rand_access(1'b0);
            req.valid <= 1'b0;
        end

        wait_quiet();

        $display("run covered %0d requests over %0d configuration phases plus the table",
                 accepted, N_PHASES);
        $display("%0d results checked, port frozen in final phase: %0d, mismatches: %0d",
                 checked, freeze_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
